// ----- hdl/imu_motion_detector_top_assert.svh -----
// assertion macros for the motion detector checker
`ifndef IMU_MOTION_DETECTOR_TOP_ASSERT_SVH
`define IMU_MOTION_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define IMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/imd_pkg.sv -----
// shared constants and codes of the motion detector
package imd_pkg;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACT_W = 24;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int DIG_W = 4;
    localparam logic [ACT_W-1:0] ACT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_ALPHA    = 3'd0,
        REG_ACT_BETA      = 3'd1,
        REG_GYRO_WEIGHT   = 3'd2,
        REG_MOVING_THR    = 3'd3,
        REG_PARKED_THR    = 3'd4,
        REG_MOVING_CONF   = 3'd5,
        REG_PARKED_CONF   = 3'd6
    } cfg_idx_t;

    localparam logic [15:0] BIAS_ALPHA_RST = 16'd1311;
    localparam logic [15:0] ACT_BETA_RST = 16'd13107;
    localparam logic [15:0] GYRO_WEIGHT_RST = 16'd655;
    localparam logic [ACT_W-1:0] MOVING_THR_RST = 24'd52429;
    localparam logic [ACT_W-1:0] PARKED_THR_RST = 24'd20972;
    localparam logic [15:0] MOVING_CONF_RST = 16'd1000;
    localparam logic [15:0] PARKED_CONF_RST = 16'd3000;

    localparam logic [2:0] AX_ACC_LAST = 3'd2;
    localparam logic [2:0] AX_RATE_FIRST = 3'd3;
    localparam logic [2:0] AX_RATE_LAST = 3'd5;
endpackage

// ----- hdl/imd_if.sv -----
// sample and result channel interfaces
interface imd_sample_if
    import imd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] rate_x;
    logic signed [SAMPLE_BITS-1:0] rate_y;
    logic signed [SAMPLE_BITS-1:0] rate_z;
    logic [31:0]                   time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    time_ms, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  time_ms, output ready);
endinterface

interface imd_result_if
    import imd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             moving;
    logic             changed;
    logic [ACT_W-1:0] activity_level;

    modport source (output valid, moving, changed, activity_level, input ready);
    modport sink (input valid, moving, changed, activity_level, output ready);
endinterface

// ----- hdl/imu_motion_detector_top.sv -----
// moving/parked classifier for imu samples, digit-serial datapath
// the shared 4-bit-per-cycle multiplier serves the bias, square, gyro weight and average steps,
// each run stepping through the factor until its remaining digits are zero; an iterative square
// root runs per vector, and the result is registered at the end
// one word at a time: the next word is taken only after the result is registered
// reset: trackers unseeded, parked, no pending condition, registers at their defaults
module imu_motion_detector_top
    import imd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    imd_sample_if.sink           sample,
    imd_result_if.source         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int SW = SAMPLE_BITS;
    localparam int DW = SW + 9;
    localparam int QW = 2 * SW + 18;
    localparam int PW = (2 * SW + 19 > 42) ? 2 * SW + 19 : 42;
    localparam int RW = SW + 12;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_TRK_SET = 8'b0000_0010,
        ST_TRK_MUL = 8'b0000_0100,
        ST_SQ_MUL  = 8'b0000_1000,
        ST_ROOT    = 8'b0001_0000,
        ST_GYR_MUL = 8'b0010_0000,
        ST_AVG_MUL = 8'b0100_0000,
        ST_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [15:0]      bias_alpha_reg;
    logic [15:0]      act_beta_reg;
    logic [15:0]      gyro_weight_reg;
    logic [ACT_W-1:0] moving_thr_reg;
    logic [ACT_W-1:0] parked_thr_reg;
    logic [15:0]      moving_conf_reg;
    logic [15:0]      parked_conf_reg;

    logic signed [SW-1:0] samp_reg [6];
    logic signed [DW-1:0] est_reg [6];
    logic [31:0]          time_reg;
    logic [2:0]           ax_reg;
    logic                 seeded_reg;
    logic                 moving_reg;
    logic                 pending_reg;
    logic [31:0]          cstart_reg;
    logic [ACT_W-1:0]     avg_reg;
    logic [ACT_W-1:0]     avg_new_reg;

    logic signed [PW-1:0] mul_a_reg;
    logic [DW-1:0]        mul_b_reg;
    logic signed [PW-1:0] mul_acc_reg;
    logic signed [PW+4:0] mul_pp;
    logic                 mul_done;

    logic [QW-1:0]        sq_acc_reg;
    logic [QW-1:0]        sqv_reg;
    logic [QW-1:0]        sq_sum;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic [RW-1:0]        rem_next;
    logic [DW-1:0]        root_reg;
    logic [DW-1:0]        root_next;
    logic [CW-1:0]        root_cnt_reg;
    logic [DW-1:0]        lin_reg;

    logic                 res_valid_reg;
    logic                 res_moving_reg;
    logic                 res_changed_reg;
    logic [ACT_W-1:0]     res_level_reg;

    logic signed [DW-1:0] t_ext;
    logic signed [DW-1:0] est_cur;
    logic signed [PW-1:0] upd;
    logic signed [DW-1:0] est_new;
    logic signed [DW-1:0] d_val;
    logic [DW-1:0]        abs_d;
    logic signed [PW-1:0] act_sum;
    logic [ACT_W-1:0]     act_sat;
    logic signed [PW-1:0] avg_diff;
    logic signed [PW-1:0] avg_upd;

    logic                 cond;
    logic [31:0]          elapsed;
    logic [15:0]          confirm;
    logic                 out_free;
    logic                 moving_next;
    logic                 pending_next;
    logic [31:0]          cstart_next;

    assign sample.ready          = (state_reg == ST_IDLE);
    assign result.valid          = res_valid_reg;
    assign result.moving         = res_moving_reg;
    assign result.changed        = res_changed_reg;
    assign result.activity_level = res_level_reg;

    // tracker datapath
    assign t_ext    = DW'($signed({samp_reg[0], 8'b0}));
    assign est_cur  = seeded_reg ? est_reg[0] : t_ext;
    assign mul_pp   = mul_a_reg * $signed({1'b0, mul_b_reg[DIG_W-1:0]});
    assign mul_done = (mul_b_reg == '0);
    assign upd      = mul_acc_reg >>> 16;
    assign est_new  = est_reg[0] + upd[DW-1:0];
    assign d_val    = t_ext - est_new;
    assign abs_d    = d_val[DW-1] ? DW'(-d_val) : DW'(d_val);
    assign sq_sum   = sq_acc_reg + mul_acc_reg[QW-1:0];

    // square root step
    assign rem_sh = {rem_reg[RW-3:0], sqv_reg[QW-1:QW-2]};
    assign trial  = RW'({root_reg, 2'b01});

    always_comb
    begin
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[DW-2:0], 1'b0};
        end
    end

    // activity and average
    assign act_sum  = PW'(lin_reg) + (mul_acc_reg >>> 8);
    assign act_sat  = (act_sum > PW'(ACT_MAX)) ? ACT_MAX : act_sum[ACT_W-1:0];
    assign avg_diff = PW'(act_sat) - PW'(avg_reg);
    assign avg_upd  = mul_acc_reg >>> 16;

    // hysteresis
    assign cond     = moving_reg ? (avg_new_reg < parked_thr_reg)
                                 : (avg_new_reg > moving_thr_reg);
    assign elapsed  = time_reg - cstart_reg;
    assign confirm  = moving_reg ? parked_conf_reg : moving_conf_reg;
    assign out_free = !res_valid_reg || result.ready;

    always_comb
    begin
        moving_next  = moving_reg;
        pending_next = pending_reg;
        cstart_next  = cstart_reg;
        if (!cond)
        begin
            pending_next = 1'b0;
        end
        else if (!pending_reg)
        begin
            pending_next = 1'b1;
            cstart_next  = time_reg;
        end
        else if (elapsed >= 32'(confirm))
        begin
            moving_next  = !moving_reg;
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_alpha_reg  <= BIAS_ALPHA_RST;
            act_beta_reg    <= ACT_BETA_RST;
            gyro_weight_reg <= GYRO_WEIGHT_RST;
            moving_thr_reg  <= MOVING_THR_RST;
            parked_thr_reg  <= PARKED_THR_RST;
            moving_conf_reg <= MOVING_CONF_RST;
            parked_conf_reg <= PARKED_CONF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIAS_ALPHA:  bias_alpha_reg  <= cfg_data[15:0];
                REG_ACT_BETA:    act_beta_reg    <= cfg_data[15:0];
                REG_GYRO_WEIGHT: gyro_weight_reg <= cfg_data[15:0];
                REG_MOVING_THR:  moving_thr_reg  <= cfg_data[ACT_W-1:0];
                REG_PARKED_THR:  parked_thr_reg  <= cfg_data[ACT_W-1:0];
                REG_MOVING_CONF: moving_conf_reg <= cfg_data[15:0];
                REG_PARKED_CONF: parked_conf_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            moving_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            cstart_reg    <= '0;
            avg_reg       <= '0;
            res_valid_reg <= 1'b0;
            ax_reg        <= '0;
            for (int i = 0; i < 6; i++)
            begin
                est_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_FIN && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        samp_reg[0] <= sample.accel_x;
                        samp_reg[1] <= sample.accel_y;
                        samp_reg[2] <= sample.accel_z;
                        samp_reg[3] <= sample.rate_x;
                        samp_reg[4] <= sample.rate_y;
                        samp_reg[5] <= sample.rate_z;
                        time_reg    <= sample.time_ms;
                        ax_reg      <= '0;
                        sq_acc_reg  <= '0;
                        state_reg   <= ST_TRK_SET;
                    end
                end
                ST_TRK_SET:
                begin
                    if (!seeded_reg)
                    begin
                        est_reg[0] <= t_ext;
                    end
                    mul_a_reg   <= PW'(t_ext - est_cur);
                    mul_b_reg   <= DW'(bias_alpha_reg);
                    mul_acc_reg <= '0;
                    state_reg   <= ST_TRK_MUL;
                end
                ST_TRK_MUL, ST_SQ_MUL, ST_GYR_MUL, ST_AVG_MUL:
                begin
                    if (!mul_done)
                    begin
                        mul_acc_reg <= mul_acc_reg + mul_pp[PW-1:0];
                        mul_a_reg   <= mul_a_reg <<< DIG_W;
                        mul_b_reg   <= mul_b_reg >> DIG_W;
                    end
                    else if (state_reg == ST_TRK_MUL)
                    begin
                        est_reg[0]  <= est_new;
                        mul_a_reg   <= PW'(abs_d);
                        mul_b_reg   <= abs_d;
                        mul_acc_reg <= '0;
                        state_reg   <= ST_SQ_MUL;
                    end
                    else if (state_reg == ST_SQ_MUL)
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            samp_reg[i] <= samp_reg[i+1];
                            est_reg[i]  <= est_reg[i+1];
                        end
                        samp_reg[5] <= samp_reg[0];
                        est_reg[5]  <= est_reg[0];
                        ax_reg      <= ax_reg + 3'd1;
                        if (ax_reg == AX_ACC_LAST || ax_reg == AX_RATE_LAST)
                        begin
                            sqv_reg      <= sq_sum;
                            sq_acc_reg   <= '0;
                            rem_reg      <= '0;
                            root_reg     <= '0;
                            root_cnt_reg <= '0;
                            state_reg    <= ST_ROOT;
                        end
                        else
                        begin
                            sq_acc_reg <= sq_sum;
                            state_reg  <= ST_TRK_SET;
                        end
                    end
                    else if (state_reg == ST_GYR_MUL)
                    begin
                        mul_a_reg   <= avg_diff;
                        mul_b_reg   <= DW'(act_beta_reg);
                        mul_acc_reg <= '0;
                        state_reg   <= ST_AVG_MUL;
                    end
                    else
                    begin
                        avg_new_reg <= avg_reg + avg_upd[ACT_W-1:0];
                        state_reg   <= ST_FIN;
                    end
                end
                ST_ROOT:
                begin
                    rem_reg      <= rem_next;
                    root_reg     <= root_next;
                    sqv_reg      <= sqv_reg << 2;
                    root_cnt_reg <= root_cnt_reg + CW'(1);
                    if (root_cnt_reg == CW'(DW - 1))
                    begin
                        if (ax_reg == AX_RATE_FIRST)
                        begin
                            lin_reg   <= root_next;
                            state_reg <= ST_TRK_SET;
                        end
                        else
                        begin
                            mul_a_reg   <= PW'(root_next);
                            mul_b_reg   <= DW'(gyro_weight_reg);
                            mul_acc_reg <= '0;
                            state_reg   <= ST_GYR_MUL;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        seeded_reg      <= 1'b1;
                        avg_reg         <= avg_new_reg;
                        moving_reg      <= moving_next;
                        pending_reg     <= pending_next;
                        cstart_reg      <= cstart_next;
                        res_moving_reg  <= moving_next;
                        res_changed_reg <= (moving_next != moving_reg);
                        res_level_reg   <= avg_new_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- hdl/imd_checker.sv -----
// port-level checker for the motion detector, bound to the top level
`include "imu_motion_detector_top_assert.svh"

module imd_checker
    import imd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic             moving,
    input logic             changed,
    input logic [ACT_W-1:0] activity_level
);
    logic prev_moving_reg;
    logic first_reg;
    logic out_acc;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_moving_reg <= 1'b0;
            first_reg       <= 1'b1;
        end
        else if (out_acc)
        begin
            prev_moving_reg <= moving;
            first_reg       <= 1'b0;
        end
    end

    `IMD_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken at once")
    `IMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `IMD_ASSERT_NOW(a_changed, out_acc, changed == (moving != prev_moving_reg),
        "changed flag disagrees with state")
    `IMD_ASSERT_NOW(a_first, out_acc && first_reg, activity_level == '0 && !changed,
        "first result not quiet")
endmodule

bind imu_motion_detector_top imd_checker u_imd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample.valid),
    .in_ready       (sample.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .moving         (result.moving),
    .changed        (result.changed),
    .activity_level (result.activity_level)
);

// ----- tb/sv/tb_imu_motion_detector_top.sv -----
// testbench for the imu motion detector: directed and random samples against a predictor
`timescale 1ns / 1ps

module tb_imu_motion_detector_top;
    import imd_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE_CYCLES = 250;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic             moving;
        logic             changed;
        logic [ACT_W-1:0] activity_level;
    } status_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    imd_sample_if sample_ch ();
    imd_result_if result_ch ();

    imu_motion_detector_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] k_alpha, k_beta, k_gweight, k_mconf, k_pconf;
    logic [ACT_W-1:0] k_mthr, k_pthr;
    longint tracker [6];
    logic [ACT_W-1:0] avg_level;
    bit seeded, moving_now, pending;
    logic [31:0] cond_start;

    status_t status_q [$];
    int errors;
    int cycles;
    bit idle_en;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_imu_motion_detector_top: done, errors");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned residual_mag(int base, longint x0, longint x1, longint x2);
        longint x [3];
        longint t;
        longint d;
        longint unsigned sq;
        x[0] = x0;
        x[1] = x1;
        x[2] = x2;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = x[i] * 256;
            if (!seeded)
                tracker[base + i] = t;
            tracker[base + i] += (longint'(k_alpha) * (t - tracker[base + i])) >>> 16;
            d = t - tracker[base + i];
            sq += longint'(d * d);
        end
        return int_sqrt(sq);
    endfunction

    task automatic predict_status(logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] az, logic signed [15:0] rx,
                                  logic signed [15:0] ry, logic signed [15:0] rz,
                                  logic [31:0] now);
        longint unsigned lin_mag, rate_mag, act;
        longint next_avg;
        bit was_moving, cond;
        status_t s;
        was_moving = moving_now;
        lin_mag = residual_mag(0, longint'(ax), longint'(ay), longint'(az));
        rate_mag = residual_mag(3, longint'(rx), longint'(ry), longint'(rz));
        seeded = 1'b1;
        act = lin_mag + ((rate_mag * k_gweight) >> 8);
        if (act > ACT_MAX)
            act = 64'(ACT_MAX);
        next_avg = longint'(avg_level)
            + ((longint'(k_beta) * (longint'(act) - longint'(avg_level))) >>> 16);
        avg_level = next_avg[ACT_W-1:0];
        cond = moving_now ? (avg_level < k_pthr) : (avg_level > k_mthr);
        if (!cond)
            pending = 1'b0;
        else if (!pending)
        begin
            pending = 1'b1;
            cond_start = now;
        end
        else if (32'(now - cond_start) >= (moving_now ? k_pconf : k_mconf))
        begin
            moving_now = !moving_now;
            pending = 1'b0;
        end
        s.moving = moving_now;
        s.changed = moving_now != was_moving;
        s.activity_level = avg_level;
        status_q.push_back(s);
    endtask

    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: moving %0b changed %0b level %0d",
                             result_ch.moving, result_ch.changed, result_ch.activity_level);
            end
            else
            begin
                want = status_q.pop_front();
                if (result_ch.moving !== want.moving || result_ch.changed !== want.changed
                    || result_ch.activity_level !== want.activity_level)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0b/%0b/%0d got %0b/%0b/%0d",
                                 want.moving, want.changed, want.activity_level,
                                 result_ch.moving, result_ch.changed,
                                 result_ch.activity_level);
                end
            end
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 9) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
                @(negedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                               logic [31:0] now);
        if (idle_en && $urandom_range(0, 9) == 0)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        sample_ch.rate_x <= rx;
        sample_ch.rate_y <= ry;
        sample_ch.rate_z <= rz;
        sample_ch.time_ms <= now;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predict_status(ax, ay, az, rx, ry, rz, now);
    endtask

    task automatic drain();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        wait (status_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BIAS_ALPHA: k_alpha = value[15:0];
            REG_ACT_BETA: k_beta = value[15:0];
            REG_GYRO_WEIGHT: k_gweight = value[15:0];
            REG_MOVING_THR: k_mthr = value;
            REG_PARKED_THR: k_pthr = value;
            REG_MOVING_CONF: k_mconf = value[15:0];
            REG_PARKED_CONF: k_pconf = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] a, logic [15:0] b, logic [15:0] g,
                             logic [23:0] mt, logic [23:0] pt, logic [15:0] mc,
                             logic [15:0] pc);
        write_reg(REG_BIAS_ALPHA, CFG_W'(a));
        write_reg(REG_ACT_BETA, CFG_W'(b));
        write_reg(REG_GYRO_WEIGHT, CFG_W'(g));
        write_reg(REG_MOVING_THR, mt);
        write_reg(REG_PARKED_THR, pt);
        write_reg(REG_MOVING_CONF, CFG_W'(mc));
        write_reg(REG_PARKED_CONF, CFG_W'(pc));
    endtask

    task automatic test_extremes();
        // first sample seeds trackers, then field extremes and saturation
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'd33);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hffffffff);
        send_sample(16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'hffff, 32'd10);
        drain();
        write_reg(REG_UNUSED, 24'hffffff);
        write_all(16'hffff, 16'hffff, 16'hffff, 24'd0, 24'hffffff, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 32'd20);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'd20);
        send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'd20);
        send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 32'd5);
        drain();
    endtask

    task automatic test_timing_wrap();
        // confirm times across a wrapping and a backward timestamp
        write_all(16'd1311, 16'd13107, 16'd655, 24'd52429, 24'd20972, 16'd1000, 16'd3000);
        send_sample(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hfffffe00);
        for (int i = 0; i < 5; i++)
            send_sample(16'(i * 3000), 16'(-i * 2000), 16'h1000, 16'(i * 900), 16'h0000,
                        16'h0400, 32'hfffffe00 + 32'(i * 400));
        for (int i = 0; i < 5; i++)
            send_sample(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        32'd200 - 32'(i * 10) + 32'(i * 1500 * (i % 2)));
        drain();
    endtask

    task automatic run_motion(int n);
        bit active;
        logic [15:0] base [6];
        int amp;
        for (int i = 0; i < 6; i++)
            base[i] = 16'($urandom);
        active = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                active = !active;
            if ($urandom_range(0, 40) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 400);
            if ($urandom_range(0, 15) == 0)
                send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), clock_ms);
            else
            begin
                amp = active ? $urandom_range(200, 8000) : $urandom_range(0, 24);
                send_sample(base[0] + 16'($urandom_range(0, 2 * amp) - amp),
                            base[1] + 16'($urandom_range(0, 2 * amp) - amp),
                            base[2] + 16'($urandom_range(0, 2 * amp) - amp),
                            base[3] + 16'($urandom_range(0, 2 * amp) - amp),
                            base[4] + 16'($urandom_range(0, 2 * amp) - amp),
                            base[5] + 16'($urandom_range(0, 2 * amp) - amp),
                            clock_ms);
            end
        end
        drain();
    endtask

    task automatic test_random_settings();
        run_motion(300);
        write_all(16'd0, 16'd65535, 16'd0, 24'd1000, 24'd500, 16'd65535, 16'd65535);
        run_motion(250);
        write_all(16'd65535, 16'd0, 16'd65535, 24'hffffff, 24'd0, 16'd0, 16'd0);
        run_motion(100);
        write_all(16'd3000, 16'd40000, 16'd2000, 24'd80000, 24'd30000, 16'd300, 16'd600);
        run_motion(300);
        for (int p = 0; p < 3; p++)
        begin
            write_all(16'($urandom_range(0, 8000)), 16'($urandom),
                      16'($urandom_range(0, 4000)),
                      24'($urandom_range(0, 400000)), 24'($urandom_range(0, 200000)),
                      16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)));
            run_motion(250);
        end
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        write_all(16'd1311, 16'd13107, 16'd655, 24'd52429, 24'd20972, 16'd1000, 16'd3000);
        run_motion(150);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_en = 1'b1;
        clock_ms = 32'd0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BIAS_ALPHA;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.rate_x = '0;
        sample_ch.rate_y = '0;
        sample_ch.rate_z = '0;
        sample_ch.time_ms = '0;
        k_alpha = BIAS_ALPHA_RST;
        k_beta = ACT_BETA_RST;
        k_gweight = GYRO_WEIGHT_RST;
        k_mthr = MOVING_THR_RST;
        k_pthr = PARKED_THR_RST;
        k_mconf = MOVING_CONF_RST;
        k_pconf = PARKED_CONF_RST;
        for (int i = 0; i < 6; i++)
            tracker[i] = 0;
        avg_level = '0;
        seeded = 1'b0;
        moving_now = 1'b0;
        pending = 1'b0;
        cond_start = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_timing_wrap();
        test_random_settings();
        test_no_idle();
        if (status_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("tb_imu_motion_detector_top: done, clean");
        else
            $display("tb_imu_motion_detector_top: done, errors");
        $finish;
    end
endmodule
